// ----- src/fsc_pkg.sv -----
`timescale 1ns / 1ps

package fsc_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int NUM_PLANES    = 6;
    localparam int NUM_REGS      = 8;
    localparam int CFG_IW        = 3;

    // Plane entries are exact sums of two Q16.16 values.
    localparam int NW   = 33;
    localparam int CW   = 32;
    localparam int RW   = 31;
    localparam int PW   = NW + CW + 1;
    localparam int DW   = PW + 2;
    localparam int MW   = DW - 1;
    localparam int MLW  = 32;
    localparam int MHW  = MW - MLW;
    localparam int NNW  = 2 * NW + 1;
    localparam int R2W  = 2 * RW;
    localparam int R2LW = RW;
    localparam int R2HW = R2W - R2LW;
    localparam int NNLW = NW;
    localparam int NNHW = NNW - NNLW;
    localparam int SW   = 136;

    localparam int FRONT_STAGES = 6;
    localparam int QDEPTH       = 8;
    localparam int QAW          = 3;

    localparam logic [2:0] PLANE_NONE = 3'd6;

    typedef struct packed {
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_z;
        logic        [RW-1:0] radius;
    } t_sphere;

    typedef struct packed {
        logic       visible;
        logic [2:0] reject_plane;
    } t_cull_res;

    // queue status seen by the front (credit) and the back (pop)
    typedef struct packed {
        logic         empty;
        logic [QAW:0] count;
    } t_qstat;

endpackage

// ----- src/fsc_front.sv -----
`timescale 1ns / 1ps

module fsc_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  fsc_pkg::t_sphere                     i_item,
    output logic                                 o_busy,
    input  logic                                 i_cfg_valid,
    input  logic [fsc_pkg::CFG_IW-1:0]           i_cfg_index,
    input  logic [63:0]                          i_cfg_data,
    input  fsc_pkg::t_qstat                      i_qstat,
    output logic                                 o_push,
    output logic [fsc_pkg::NUM_PLANES-1:0]       o_outside
);

    localparam int NP = fsc_pkg::NUM_PLANES;

    logic [63:0] r_cfg [fsc_pkg::NUM_REGS];
    logic signed [31:0] m [4][4];

    logic [fsc_pkg::FRONT_STAGES-1:0] r_vld;
    logic accept;

    // stage A
    logic signed [fsc_pkg::NW-1:0] n_a_n [NP][3];
    logic signed [fsc_pkg::NW-1:0] n_a_d [NP];
    logic signed [fsc_pkg::NW-1:0] r_a_n [NP][3];
    logic signed [fsc_pkg::NW-1:0] r_a_d [NP];
    logic signed [fsc_pkg::CW-1:0] r_a_c [3];
    logic        [fsc_pkg::RW-1:0] r_a_r;

    // stage B
    logic signed [fsc_pkg::PW-1:0] r_b_p  [NP][3];
    logic signed [fsc_pkg::PW-1:0] r_b_sq [NP][3];
    logic signed [fsc_pkg::DW-1:0] r_b_dsh [NP];
    logic [NP-1:0]                 r_b_zero, r_b_zneg;
    logic [fsc_pkg::R2W-1:0]       r_b_r2;

    // stage C
    logic signed [fsc_pkg::DW-1:0] r_c_dist [NP];
    logic [fsc_pkg::NNW-1:0]       r_c_nn [NP];
    logic [NP-1:0]                 r_c_zero, r_c_zneg;
    logic [fsc_pkg::R2W-1:0]       r_c_r2;

    // stage D
    logic [fsc_pkg::MW-1:0]        r_d_mag [NP];
    logic [NP-1:0]                 r_d_neg, r_d_zero, r_d_zneg;
    logic [fsc_pkg::NNW-1:0]       r_d_nn [NP];
    logic [fsc_pkg::R2W-1:0]       r_d_r2;

    // stage E
    logic [2*fsc_pkg::MHW-1:0]              r_e_hh [NP];
    logic [fsc_pkg::MHW+fsc_pkg::MLW-1:0]   r_e_hl [NP];
    logic [2*fsc_pkg::MLW-1:0]              r_e_ll [NP];
    logic [fsc_pkg::R2HW+fsc_pkg::NNHW-1:0] r_e_rhnh [NP];
    logic [fsc_pkg::R2HW+fsc_pkg::NNLW-1:0] r_e_rhnl [NP];
    logic [fsc_pkg::R2LW+fsc_pkg::NNHW-1:0] r_e_rlnh [NP];
    logic [fsc_pkg::R2LW+fsc_pkg::NNLW-1:0] r_e_rlnl [NP];
    logic [NP-1:0]                          r_e_neg, r_e_zero, r_e_zneg;

    // stage F
    logic [fsc_pkg::SW-1:0] r_f_lhs [NP];
    logic [fsc_pkg::SW-1:0] r_f_rhs [NP];
    logic [NP-1:0]          r_f_neg, r_f_zero, r_f_zneg;

    logic [fsc_pkg::QAW+1:0] credit_used;

    always_comb begin
        credit_used = (fsc_pkg::QAW+2)'(i_qstat.count) + (fsc_pkg::QAW+2)'($countones(r_vld));
        o_busy      = !i_rst_n || (credit_used >= (fsc_pkg::QAW+2)'(fsc_pkg::QDEPTH));
        accept      = i_start && !o_busy;
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                m[r][c] = r_cfg[r*2 + c/2][(c%2)*32 +: 32];
            end
        end
        for (int p = 0; p < NP; p++) begin
            for (int j = 0; j < 3; j++) begin
                if (p % 2 == 1) begin
                    n_a_n[p][j] = fsc_pkg::NW'(m[3][j]) - fsc_pkg::NW'(m[p/2][j]);
                end else begin
                    n_a_n[p][j] = fsc_pkg::NW'(m[3][j]) + fsc_pkg::NW'(m[p/2][j]);
                end
            end
            if (p % 2 == 1) begin
                n_a_d[p] = fsc_pkg::NW'(m[3][3]) - fsc_pkg::NW'(m[p/2][3]);
            end else begin
                n_a_d[p] = fsc_pkg::NW'(m[3][3]) + fsc_pkg::NW'(m[p/2][3]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fsc_pkg::NUM_REGS; i++) r_cfg[i] <= '0;
            r_vld <= '0;
        end else begin
            if (i_cfg_valid) r_cfg[i_cfg_index] <= i_cfg_data;
            r_vld <= {r_vld[fsc_pkg::FRONT_STAGES-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        // A: planes from the clip matrix
        r_a_n    <= n_a_n;
        r_a_d    <= n_a_d;
        r_a_c[0] <= i_item.center_x;
        r_a_c[1] <= i_item.center_y;
        r_a_c[2] <= i_item.center_z;
        r_a_r    <= i_item.radius;

        // B: products
        r_b_r2 <= fsc_pkg::R2W'(r_a_r) * fsc_pkg::R2W'(r_a_r);
        for (int p = 0; p < NP; p++) begin
            for (int j = 0; j < 3; j++) begin
                r_b_p[p][j]  <= fsc_pkg::PW'(r_a_n[p][j]) * fsc_pkg::PW'(r_a_c[j]);
                r_b_sq[p][j] <= fsc_pkg::PW'(r_a_n[p][j]) * fsc_pkg::PW'(r_a_n[p][j]);
            end
            r_b_dsh[p]  <= fsc_pkg::DW'(r_a_d[p]) <<< fsc_pkg::FRACTION_BITS;
            r_b_zero[p] <= (r_a_n[p][0] == '0) && (r_a_n[p][1] == '0) && (r_a_n[p][2] == '0);
            r_b_zneg[p] <= (fsc_pkg::DW'(r_a_d[p]) + fsc_pkg::DW'($signed({1'b0, r_a_r}))) < 0;
        end

        // C: distance and squared normal length
        r_c_r2   <= r_b_r2;
        r_c_zero <= r_b_zero;
        r_c_zneg <= r_b_zneg;
        for (int p = 0; p < NP; p++) begin
            r_c_dist[p] <= fsc_pkg::DW'(r_b_p[p][0]) + fsc_pkg::DW'(r_b_p[p][1])
                         + fsc_pkg::DW'(r_b_p[p][2]) + r_b_dsh[p];
            r_c_nn[p]   <= fsc_pkg::NNW'(r_b_sq[p][0]) + fsc_pkg::NNW'(r_b_sq[p][1])
                         + fsc_pkg::NNW'(r_b_sq[p][2]);
        end

        // D: magnitude
        r_d_r2   <= r_c_r2;
        r_d_zero <= r_c_zero;
        r_d_zneg <= r_c_zneg;
        r_d_nn   <= r_c_nn;
        for (int p = 0; p < NP; p++) begin
            r_d_neg[p] <= r_c_dist[p][fsc_pkg::DW-1];
            r_d_mag[p] <= r_c_dist[p][fsc_pkg::DW-1] ? fsc_pkg::MW'(-r_c_dist[p])
                                                     : fsc_pkg::MW'(r_c_dist[p]);
        end

        // E: partial products of both squares
        r_e_neg  <= r_d_neg;
        r_e_zero <= r_d_zero;
        r_e_zneg <= r_d_zneg;
        for (int p = 0; p < NP; p++) begin
            r_e_hh[p] <= (2*fsc_pkg::MHW)'(r_d_mag[p][fsc_pkg::MW-1:fsc_pkg::MLW])
                       * (2*fsc_pkg::MHW)'(r_d_mag[p][fsc_pkg::MW-1:fsc_pkg::MLW]);
            r_e_hl[p] <= (fsc_pkg::MHW+fsc_pkg::MLW)'(r_d_mag[p][fsc_pkg::MW-1:fsc_pkg::MLW])
                       * (fsc_pkg::MHW+fsc_pkg::MLW)'(r_d_mag[p][fsc_pkg::MLW-1:0]);
            r_e_ll[p] <= (2*fsc_pkg::MLW)'(r_d_mag[p][fsc_pkg::MLW-1:0])
                       * (2*fsc_pkg::MLW)'(r_d_mag[p][fsc_pkg::MLW-1:0]);
            r_e_rhnh[p] <= (fsc_pkg::R2HW+fsc_pkg::NNHW)'(r_d_r2[fsc_pkg::R2W-1:fsc_pkg::R2LW])
                         * (fsc_pkg::R2HW+fsc_pkg::NNHW)'(r_d_nn[p][fsc_pkg::NNW-1:fsc_pkg::NNLW]);
            r_e_rhnl[p] <= (fsc_pkg::R2HW+fsc_pkg::NNLW)'(r_d_r2[fsc_pkg::R2W-1:fsc_pkg::R2LW])
                         * (fsc_pkg::R2HW+fsc_pkg::NNLW)'(r_d_nn[p][fsc_pkg::NNLW-1:0]);
            r_e_rlnh[p] <= (fsc_pkg::R2LW+fsc_pkg::NNHW)'(r_d_r2[fsc_pkg::R2LW-1:0])
                         * (fsc_pkg::R2LW+fsc_pkg::NNHW)'(r_d_nn[p][fsc_pkg::NNW-1:fsc_pkg::NNLW]);
            r_e_rlnl[p] <= (fsc_pkg::R2LW+fsc_pkg::NNLW)'(r_d_r2[fsc_pkg::R2LW-1:0])
                         * (fsc_pkg::R2LW+fsc_pkg::NNLW)'(r_d_nn[p][fsc_pkg::NNLW-1:0]);
        end

        // F: recombine
        r_f_neg  <= r_e_neg;
        r_f_zero <= r_e_zero;
        r_f_zneg <= r_e_zneg;
        for (int p = 0; p < NP; p++) begin
            r_f_lhs[p] <= (fsc_pkg::SW'(r_e_hh[p]) << (2*fsc_pkg::MLW))
                        + (fsc_pkg::SW'(r_e_hl[p]) << (fsc_pkg::MLW+1))
                        + fsc_pkg::SW'(r_e_ll[p]);
            r_f_rhs[p] <= (fsc_pkg::SW'(r_e_rhnh[p]) << (fsc_pkg::R2LW+fsc_pkg::NNLW))
                        + (fsc_pkg::SW'(r_e_rhnl[p]) << fsc_pkg::R2LW)
                        + (fsc_pkg::SW'(r_e_rlnh[p]) << fsc_pkg::NNLW)
                        + fsc_pkg::SW'(r_e_rlnl[p]);
        end
    end

    always_comb begin
        o_push = r_vld[fsc_pkg::FRONT_STAGES-1];
        for (int p = 0; p < NP; p++) begin
            // touching the plane does not reject
            o_outside[p] = r_f_zero[p] ? r_f_zneg[p]
                                       : (r_f_neg[p] && (r_f_lhs[p] > r_f_rhs[p]));
        end
    end

endmodule

// ----- src/fsc_queue.sv -----
`timescale 1ns / 1ps

module fsc_queue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic [fsc_pkg::NUM_PLANES-1:0]     i_data,
    input  logic                               i_pop,
    output logic [fsc_pkg::NUM_PLANES-1:0]     o_data,
    output fsc_pkg::t_qstat                    o_stat
);

    logic [fsc_pkg::NUM_PLANES-1:0] r_mem [fsc_pkg::QDEPTH];
    logic [fsc_pkg::QAW-1:0] r_wr, r_rd;
    logic [fsc_pkg::QAW:0]   r_count;
    logic do_pop;

    assign do_pop        = i_pop && (r_count != '0);
    assign o_data        = r_mem[r_rd];
    assign o_stat.empty  = (r_count == '0);
    assign o_stat.count  = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (do_pop) r_rd <= r_rd + 1'b1;
            r_count <= r_count + (fsc_pkg::QAW+1)'(i_push) - (fsc_pkg::QAW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

// ----- src/fsc_back.sv -----
`timescale 1ns / 1ps

module fsc_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fsc_pkg::t_qstat                    i_qstat,
    input  logic [fsc_pkg::NUM_PLANES-1:0]     i_outside,
    output logic                               o_pop,
    output logic                               o_valid,
    output fsc_pkg::t_cull_res                 o_result
);

    logic                r_valid;
    fsc_pkg::t_cull_res  r_result;
    fsc_pkg::t_cull_res  n_result;

    assign o_pop = !i_qstat.empty;

    // first rejecting plane wins
    always_comb begin
        n_result.visible      = 1'b1;
        n_result.reject_plane = fsc_pkg::PLANE_NONE;
        for (int p = fsc_pkg::NUM_PLANES - 1; p >= 0; p--) begin
            if (i_outside[p]) begin
                n_result.visible      = 1'b0;
                n_result.reject_plane = 3'(p);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= o_pop;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- src/frustum_sphere_cull_unit.sv -----
`timescale 1ns / 1ps

// Frustum culling of bounding spheres against six planes formed from the
// clip matrix (left, right, bottom, top, near, far).
// Item channel: drive i_item and raise i_start; the beat is taken on a
// clock edge where o_busy is low. One sphere per cycle is sustained.
// Result channel: o_valid is high for one cycle with o_result; it cannot
// be held off. Results come in item order, through a 6-stage arithmetic
// front (plane forming, dot products, distance, magnitude, split squares,
// recombine), an 8-entry queue and a result register in the back.
// o_busy is a credit check on the queue; it never rises while results
// flow freely, only during reset.
// Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index (0..7) and
// 64-bit i_cfg_data, two signed Q16.16 entries of one matrix row per
// register. Write only while no item is in flight.
// Reset (synchronous, active low) clears the matrix to zero and empties
// the pipeline and queue; no clearing pass is needed.
module frustum_sphere_cull_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  fsc_pkg::t_sphere              i_item,
    output logic                          o_busy,
    output logic                          o_valid,
    output fsc_pkg::t_cull_res            o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fsc_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [63:0]                   i_cfg_data
);

    fsc_pkg::t_qstat qstat;
    logic push, pop;
    logic [fsc_pkg::NUM_PLANES-1:0] outside_in, outside_out;
    logic cfg_wr;

    assign o_cfg_ready = i_rst_n;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    fsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_item      (i_item),
        .o_busy      (o_busy),
        .i_cfg_valid (cfg_wr),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_outside   (outside_in)
    );

    fsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (outside_in),
        .i_pop   (pop),
        .o_data  (outside_out),
        .o_stat  (qstat)
    );

    fsc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_qstat   (qstat),
        .i_outside (outside_out),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

endmodule

// ----- tb/sv/tb_frustum_sphere_cull_unit.sv -----
`timescale 1ns / 1ps

module tb_frustum_sphere_cull_unit;

    localparam int LIMIT_CYCLES = 400000;

    typedef enum int {
        REG_R1_C12 = 0, REG_R1_C34 = 1, REG_R2_C12 = 2, REG_R2_C34 = 3,
        REG_R3_C12 = 4, REG_R3_C34 = 5, REG_R4_C12 = 6, REG_R4_C34 = 7
    } t_reg_idx;

    typedef enum int {
        PL_LEFT = 0, PL_RIGHT = 1, PL_BOTTOM = 2, PL_TOP = 3, PL_NEAR = 4, PL_FAR = 5
    } t_plane;

    class cull_scoreboard;
        logic [63:0] clip [fsc_pkg::NUM_REGS];
        fsc_pkg::t_cull_res pending[$];
        int errors;

        function new();
            foreach (clip[i]) clip[i] = '0;
            errors = 0;
        endfunction

        function logic signed [63:0] entry(int row, int col);
            logic [63:0] r;
            r = clip[row * 2 + col / 2];
            return (col % 2) ? 64'(signed'(r[63:32])) : 64'(signed'(r[31:0]));
        endfunction

        // exact test: outside when D < 0 and D^2 > r^2 |n|^2; with a zero normal, when d + r < 0
        function bit plane_rejects(int p, fsc_pkg::t_sphere s);
            logic signed [63:0] n [3];
            logic signed [63:0] d;
            logic signed [63:0] c [3];
            logic signed [159:0] dsum, lhs, rhs, nn, rr;
            int row;
            bit minus;
            row = p / 2;
            minus = p % 2;
            c[0] = 64'(s.center_x);
            c[1] = 64'(s.center_y);
            c[2] = 64'(s.center_z);
            for (int j = 0; j < 3; j++)
                n[j] = minus ? entry(3, j) - entry(row, j) : entry(3, j) + entry(row, j);
            d = minus ? entry(3, 3) - entry(row, 3) : entry(3, 3) + entry(row, 3);
            rr = 160'(s.radius);
            if (n[0] == 0 && n[1] == 0 && n[2] == 0)
                return (160'(d) + rr) < 0;
            dsum = 160'(d) <<< fsc_pkg::FRACTION_BITS;
            nn = 0;
            for (int j = 0; j < 3; j++) begin
                dsum += 160'(n[j]) * 160'(c[j]);
                nn += 160'(n[j]) * 160'(n[j]);
            end
            if (dsum >= 0) return 0;
            lhs = dsum * dsum;
            rhs = rr * rr * nn;
            return lhs > rhs;
        endfunction

        function void note_sphere(fsc_pkg::t_sphere s);
            fsc_pkg::t_cull_res r;
            r.visible = 1'b1;
            r.reject_plane = fsc_pkg::PLANE_NONE;
            for (int p = PL_LEFT; p <= PL_FAR; p++)
                if (plane_rejects(p, s)) begin
                    r.visible = 1'b0;
                    r.reject_plane = 3'(p);
                    break;
                end
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(fsc_pkg::t_cull_res got);
            fsc_pkg::t_cull_res want;
            if (pending.size() == 0) begin
                $error("unexpected result visible=%0d plane=%0d", got.visible,
                       got.reject_plane);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.visible !== want.visible) begin
                $error("visible: expected %0d actual %0d", want.visible, got.visible);
                errors++;
            end
            if (got.reject_plane !== want.reject_plane) begin
                $error("reject_plane: expected %0d actual %0d", want.reject_plane,
                       got.reject_plane);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_start = 0, i_cfg_valid = 0;
    fsc_pkg::t_sphere i_item = '0;
    logic [fsc_pkg::CFG_IW-1:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic o_busy, o_valid, o_cfg_ready;
    fsc_pkg::t_cull_res o_result;

    cull_scoreboard sb = new();
    int cycle = 0;
    int idle_pct = 0;

    frustum_sphere_cull_unit dut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (i_rst_n && o_valid) sb.check_result(o_result);
        if (cycle > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_clip(t_reg_idx idx, logic [63:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= fsc_pkg::CFG_IW'(idx);
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.clip[idx] = val;
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // beat is taken at the edge where start is high and busy low
    task automatic send_sphere(fsc_pkg::t_sphere s);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 0;
            @(posedge i_clk);
        end
        i_start <= 1;
        i_item <= s;
        do @(posedge i_clk); while (o_busy);
        sb.note_sphere(s);
    endtask

    function automatic logic [31:0] rnd_q16(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
        endcase
    endfunction

    function automatic fsc_pkg::t_sphere rnd_sphere(int mode);
        fsc_pkg::t_sphere s;
        s.center_x = rnd_q16(mode);
        s.center_y = rnd_q16(mode);
        s.center_z = rnd_q16(mode);
        s.radius = (mode == 0) ? fsc_pkg::RW'($urandom)
                               : fsc_pkg::RW'($urandom_range(0, 3 << 16));
        return s;
    endfunction

    task automatic load_matrix(int mode);
        for (int i = REG_R1_C12; i <= REG_R4_C34; i++)
            write_clip(t_reg_idx'(i), {rnd_q16(mode), rnd_q16(mode)});
    endtask

    // perspective-like matrix in Q16.16: rows 1..2 diag, row 3 = (0, 0, -1, -2), row 4 = -z
    task automatic load_perspective();
        write_clip(REG_R1_C12, {32'd0, 32'h0001_0000});
        write_clip(REG_R1_C34, 64'd0);
        write_clip(REG_R2_C12, {32'h0001_0000, 32'd0});
        write_clip(REG_R2_C34, 64'd0);
        write_clip(REG_R3_C12, 64'd0);
        write_clip(REG_R3_C34, {32'hFFFE_0000, 32'hFFFF_0000});
        write_clip(REG_R4_C12, 64'd0);
        write_clip(REG_R4_C34, {32'd0, 32'hFFFF_0000});
    endtask

    initial begin
        fsc_pkg::t_sphere s;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // all-zero matrix: every plane has zero normal, d = 0
        s = '0;
        send_sphere(s);
        s.radius = '1;
        send_sphere(s);
        i_start <= 0;
        wait_drained();

        load_perspective();
        for (int k = 0; k < 8; k++) begin
            s.center_x = (k == 0) ? 32'h8000_0000 : (k == 1) ? 32'h7FFF_FFFF : rnd_q16(1);
            s.center_y = (k == 2) ? 32'h8000_0000 : (k == 3) ? 32'h7FFF_FFFF : rnd_q16(1);
            s.center_z = (k == 4) ? 32'h8000_0000 : (k == 5) ? 32'h7FFF_FFFF : rnd_q16(1);
            s.radius = (k == 6) ? '1 : (k == 7) ? '0 : fsc_pkg::RW'($urandom_range(0, 1 << 16));
            send_sphere(s);
        end
        // spheres of radius 2.0 and just under, centred at x = -2
        s.center_x = 32'hFFFE_0000; s.center_y = 0; s.center_z = 0; s.radius = 31'h2_0000;
        send_sphere(s);
        s.radius = 31'h1_FFFF;
        send_sphere(s);
        i_start <= 0;
        wait_drained();

        // zero-normal planes with d extremes
        write_clip(REG_R1_C12, 64'd0); write_clip(REG_R2_C12, 64'd0);
        write_clip(REG_R3_C12, 64'd0); write_clip(REG_R4_C12, 64'd0);
        write_clip(REG_R1_C34, {32'h7FFF_FFFF, 32'd0});
        write_clip(REG_R2_C34, {32'h8000_0000, 32'd0});
        write_clip(REG_R3_C34, {32'h0000_0001, 32'd0});
        write_clip(REG_R4_C34, {32'h8000_0000, 32'd0});
        for (int k = 0; k < 4; k++) send_sphere(rnd_sphere(k % 3));
        i_start <= 0;
        wait_drained();

        // extreme matrix: every entry at the most negative value
        for (int i = REG_R1_C12; i <= REG_R4_C34; i++)
            write_clip(t_reg_idx'(i), 64'h8000_0000_8000_0000);
        for (int k = 0; k < 3; k++) send_sphere(rnd_sphere(0));
        i_start <= 0;
        wait_drained();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 71;
                default: idle_pct = 11;
            endcase
            if (ph % 4 == 0) load_perspective();
            else load_matrix(ph % 3);
            for (int k = 0; k < 120; k++)
                send_sphere(rnd_sphere((ph + k) % 4 == 0 ? 0 : ($urandom_range(1) + 1)));
            i_start <= 0;
            wait_drained();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
